// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the execute step block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== rtl/mse_pkg.sv =====
// Shared types and codes of the execute step block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mse_pkg;

	localparam int DATA_WORDS_DEF = 256;

	localparam logic [1:0] FN_PRELOAD = 2'd0;
	localparam logic [1:0] FN_START   = 2'd1;
	localparam logic [1:0] FN_EXEC    = 2'd2;

	localparam logic CFG_PC = 1'b0;
	localparam logic CFG_SP = 1'b1;

	localparam logic [5:0] OP_RTYPE   = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDI_NV = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_NORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2b;

	localparam logic [5:0] F_SLL  = 6'h00;
	localparam logic [5:0] F_SRL  = 6'h02;
	localparam logic [5:0] F_SRA  = 6'h03;
	localparam logic [5:0] F_JR   = 6'h08;
	localparam logic [5:0] F_ADD  = 6'h20;
	localparam logic [5:0] F_ADDU = 6'h21;
	localparam logic [5:0] F_SUB  = 6'h22;
	localparam logic [5:0] F_AND  = 6'h24;
	localparam logic [5:0] F_OR   = 6'h25;
	localparam logic [5:0] F_XOR  = 6'h26;
	localparam logic [5:0] F_NOR  = 6'h27;
	localparam logic [5:0] F_NAND = 6'h28;
	localparam logic [5:0] F_SLT  = 6'h2a;

	localparam logic [4:0] REG_SP = 5'd29;
	localparam logic [4:0] REG_RA = 5'd31;

	typedef struct packed {
		logic [31:0] pc;
		logic        stopped;
		logic        reg_we;
		logic        reg_report;
		logic [4:0]  reg_idx;
		logic [31:0] reg_val;
		logic        load;
		logic        store;
		logic        preload;
		logic [5:0]  op;
		logic [1:0]  off;
		logic [31:0] mem_idx;
		logic [31:0] wdata;
		logic        e_zero;
		logic        e_ovf;
		logic        e_addr;
		logic        e_mis;
	} exe_t;

endpackage

`default_nettype wire

// ===== rtl/mse_regfile.sv =====
// Register file: 32 words in a synchronous memory with two read ports.
// Valid bits give the reset value; the latest write is forwarded. Uses mse_pkg.
`default_nettype none

module mse_regfile
	import mse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rd_en,
	input  wire logic [4:0]  ra,
	input  wire logic [4:0]  rb,
	output logic      [31:0] a,
	output logic      [31:0] b,
	input  wire logic        we,
	input  wire logic [4:0]  widx,
	input  wire logic [31:0] wdata
);

	logic [31:0] mem [32];
	logic [31:0] vld_q;
	logic [4:0]  ra_q, rb_q;
	logic [31:0] da_q, db_q;
	logic        va_q, vb_q;
	logic        lw_vld_q;
	logic [4:0]  lw_idx_q;
	logic [31:0] lw_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[widx] <= wdata;
		end
		if (rd_en) begin
			da_q <= mem[ra];
			db_q <= mem[rb];
			ra_q <= ra;
			rb_q <= rb;
		end
		if (we) begin
			lw_idx_q  <= widx;
			lw_data_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			va_q     <= 1'b0;
			vb_q     <= 1'b0;
			lw_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[widx] <= 1'b1;
				lw_vld_q    <= 1'b1;
			end
			if (rd_en) begin
				va_q <= vld_q[ra];
				vb_q <= vld_q[rb];
			end
		end
	end

	always_comb begin
		a = va_q ? da_q : 32'd0;
		b = vb_q ? db_q : 32'd0;
		if (lw_vld_q && lw_idx_q == ra_q) begin
			a = lw_data_q;
		end
		if (lw_vld_q && lw_idx_q == rb_q) begin
			b = lw_data_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mse_dmem.sv =====
// Data memory: DATA_WORDS words in a synchronous memory, cleared after reset.
// One word per cycle is zeroed while clearing is high. Uses mse_pkg.
`default_nettype none

module mse_dmem
	import mse_pkg::*;
#(
	parameter int DATA_WORDS = DATA_WORDS_DEF,
	parameter int AddrW      = $clog2(DATA_WORDS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [AddrW-1:0] rd_idx,
	output logic      [31:0]      rd_data,
	input  wire logic             wr_en,
	input  wire logic [AddrW-1:0] wr_idx,
	input  wire logic [31:0]      wr_data,
	output logic                  clearing
);

	localparam logic [AddrW-1:0] LastIdx = AddrW'(DATA_WORDS - 1);

	logic [31:0]      mem [DATA_WORDS];
	logic             clr_q;
	logic [AddrW-1:0] cnt_q;

	assign clearing = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			cnt_q <= '0;
		end else if (clr_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LastIdx) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[cnt_q] <= 32'd0;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mse_exec.sv =====
// Decode and execute of one item: ALU, branch and jump targets, address checks.
// Combinational; uses mse_pkg for opcodes and the exe_t result.
`default_nettype none

module mse_exec
	import mse_pkg::*;
#(
	parameter int DATA_WORDS = DATA_WORDS_DEF
) (
	input  wire logic [1:0]  func,
	input  wire logic [31:0] instruction,
	input  wire logic [7:0]  load_index,
	input  wire logic [31:0] load_word,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] pc,
	input  wire logic        stopped,
	input  wire logic [31:0] initial_pc,
	input  wire logic [31:0] initial_sp,
	output exe_t             res
);

	localparam logic [32:0] MemBytes = 33'(DATA_WORDS * 4);

	logic [5:0]  op, fn;
	logic [4:0]  rt, rd, sh;
	logic [31:0] imm, uimm, next, npc, addr, br, jt, sum_ab, dif_ab, rv;
	logic [32:0] end_addr;
	logic [1:0]  sz_m1;
	logic        ovf_ai, ovf_br, ovf_add, ovf_sub, wr_ok, stop, rv_ok, fault;

	always_comb begin
		op      = instruction[31:26];
		rt      = instruction[20:16];
		rd      = instruction[15:11];
		sh      = instruction[10:6];
		fn      = instruction[5:0];
		imm     = {{16{instruction[15]}}, instruction[15:0]};
		uimm    = {16'd0, instruction[15:0]};
		next    = pc + 32'd4;
		addr    = a + imm;
		ovf_ai  = ~(a[31] ^ imm[31]) & (a[31] ^ addr[31]);
		br      = next + {imm[29:0], 2'b00};
		ovf_br  = ~(next[31] ^ imm[29]) & (next[31] ^ br[31]);
		jt      = {next[31:28], instruction[25:0], 2'b00};
		sum_ab  = a + b;
		ovf_add = ~(a[31] ^ b[31]) & (a[31] ^ sum_ab[31]);
		dif_ab  = a - b;
		ovf_sub = (a[31] ^ b[31]) & (a[31] ^ dif_ab[31]);
		case (op)
			OP_LW, OP_SW: sz_m1 = 2'd3;
			OP_LH, OP_LHU, OP_SH: sz_m1 = 2'd1;
			default: sz_m1 = 2'd0;
		endcase
		end_addr = {1'b0, addr} + 33'(sz_m1);
		wr_ok    = !((op inside {[OP_ADDI:OP_LHU]}) && rt == 5'd0);
		stop     = 1'b0;
		rv_ok    = 1'b0;
		rv       = 32'd0;
		npc      = next;
		fault    = 1'b0;

		res            = '0;
		res.pc         = pc;
		res.stopped    = stopped;
		res.op         = op;
		res.off        = addr[1:0];
		res.mem_idx    = {2'b00, addr[31:2]};
		res.wdata      = b;

		case (func)
			FN_PRELOAD: begin
				if (32'(load_index) < DATA_WORDS) begin
					res.preload = 1'b1;
					res.mem_idx = 32'(load_index);
					res.wdata   = load_word;
				end
			end
			FN_START: begin
				res.pc      = initial_pc;
				res.stopped = 1'b0;
				res.reg_we  = 1'b1;
				res.reg_idx = REG_SP;
				res.reg_val = initial_sp;
			end
			FN_EXEC: begin
				if (!stopped) begin
					res.e_zero = !wr_ok;
					res.e_addr = end_addr >= MemBytes;
					res.e_mis  = |(addr[1:0] & sz_m1);
					fault      = res.e_addr || res.e_mis;
					case (op)
						OP_RTYPE: begin
							res.e_addr = 1'b0;
							res.e_mis  = 1'b0;
							if (!(instruction[10:0] == 11'd0 && rt == 5'd0 && rd == 5'd0)) begin
								if (fn != F_JR && rd == 5'd0) begin
									res.e_zero = 1'b1;
									if (fn == F_ADD) begin
										res.e_ovf = ovf_add;
									end else if (fn == F_SUB) begin
										res.e_ovf = ovf_sub;
									end
								end else begin
									rv_ok = 1'b1;
									case (fn)
										F_ADD: begin
											rv        = sum_ab;
											res.e_ovf = ovf_add;
										end
										F_ADDU: rv = sum_ab;
										F_SUB: begin
											rv        = dif_ab;
											res.e_ovf = ovf_sub;
										end
										F_AND:  rv = a & b;
										F_OR:   rv = a | b;
										F_XOR:  rv = a ^ b;
										F_NOR:  rv = ~(a | b);
										F_NAND: rv = ~(a & b);
										F_SLT:  rv = {31'd0, $signed(a) < $signed(b)};
										F_SLL:  rv = b << sh;
										F_SRL:  rv = b >> sh;
										F_SRA:  rv = 32'($signed(b) >>> sh);
										F_JR: begin
											npc   = a;
											rv_ok = 1'b0;
										end
										default: begin
											stop  = 1'b1;
											rv_ok = 1'b0;
										end
									endcase
									res.reg_idx = rd;
								end
							end
						end
						OP_ADDI: begin
							rv_ok     = wr_ok;
							rv        = addr;
							res.e_ovf = ovf_ai;
						end
						OP_ADDI_NV: begin
							rv_ok = wr_ok;
							rv    = addr;
						end
						OP_LUI: begin
							rv_ok = wr_ok;
							rv    = {instruction[15:0], 16'd0};
						end
						OP_ANDI: begin
							rv_ok = wr_ok;
							rv    = a & uimm;
						end
						OP_ORI: begin
							rv_ok = wr_ok;
							rv    = a | uimm;
						end
						OP_NORI: begin
							rv_ok = wr_ok;
							rv    = ~(a | uimm);
						end
						OP_SLTI: begin
							rv_ok = wr_ok;
							rv    = {31'd0, $signed(a) < $signed(imm)};
						end
						OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU: begin
							res.e_ovf = ovf_ai;
							if (fault) begin
								stop = 1'b1;
							end else begin
								res.load   = 1'b1;
								res.reg_we = wr_ok;
							end
						end
						OP_SW, OP_SH, OP_SB: begin
							res.e_ovf = ovf_ai;
							if (fault) begin
								stop = 1'b1;
							end else begin
								res.store = 1'b1;
							end
						end
						OP_BEQ, OP_BNE, OP_BGTZ: begin
							res.e_ovf = ovf_br;
							if ((op == OP_BEQ && a == b) || (op == OP_BNE && a != b) ||
								(op == OP_BGTZ && a != 32'd0 && !a[31])) begin
								npc = br;
							end
						end
						OP_JAL: begin
							rv_ok       = 1'b1;
							rv          = next;
							res.reg_idx = REG_RA;
							npc         = jt;
						end
						OP_J: npc = jt;
						default: stop = 1'b1;
					endcase
					if (op != OP_RTYPE && op != OP_JAL) begin
						res.reg_idx = rt;
					end
					if (!(res.load || res.store)) begin
						res.e_addr = 1'b0;
						res.e_mis  = 1'b0;
						if (op inside {OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB}) begin
							res.e_addr = end_addr >= MemBytes;
							res.e_mis  = |(addr[1:0] & sz_m1);
						end
					end
					if (rv_ok) begin
						res.reg_we  = 1'b1;
						res.reg_val = rv;
					end
					res.reg_report = res.reg_we;
					if (stop) begin
						res.stopped    = 1'b1;
						res.reg_we     = 1'b0;
						res.reg_report = 1'b0;
						res.load       = 1'b0;
						res.store      = 1'b0;
					end else begin
						res.pc = npc;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/mips_subset_execute_step.sv =====
// Top level of the execute step block: handshake, pipeline registers, config.
// Uses mse_pkg, mse_regfile, mse_dmem, mse_exec and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_ready  | func, instruction, load_index, load_word
//   result  | out       | out_valid/out_ready| fetch_pc ... halted
//   config  | in        | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// An item reads the register file at acceptance, executes and addresses the data
// memory in the next cycle, then merges, writes back and fills the output register.
// A new item is not taken while the execute stage still holds the last one.
// After reset the data memory is zeroed with in_ready low.
// A waiting result blocks a new item only when the memory stage behind it is full.
`default_nettype none
`include "assert_macros.svh"

module mips_subset_execute_step
	import mse_pkg::*;
#(
	parameter int DATA_WORDS = DATA_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] instruction,
	input  wire logic [7:0]  load_index,
	input  wire logic [31:0] load_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] fetch_pc,
	output logic             reg_write,
	output logic      [4:0]  reg_index,
	output logic      [31:0] reg_value,
	output logic             mem_write,
	output logic      [7:0]  mem_index,
	output logic      [31:0] mem_value,
	output logic             err_write_zero,
	output logic             err_overflow,
	output logic             err_address,
	output logic             err_misaligned,
	output logic             halted,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int AddrW = $clog2(DATA_WORDS);

	logic [31:0] initial_pc_q, initial_sp_q, pc_q;
	logic        stopped_q;
	logic        s1_valid_q, s2_valid_q, out_valid_q;
	logic [1:0]  func_s1;
	logic [31:0] instr_s1, load_word_s1;
	logic [7:0]  load_index_s1;
	exe_t        exe, res_s2;
	logic [31:0] a, b, dm_rdata, w_sh, ld_val, st_val, rf_wdata;
	logic        dm_clearing, out_free, s2_done, accept;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == CFG_SP) ? initial_sp_q : initial_pc_q;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q && !dm_clearing && (!s2_valid_q || out_free);
	assign accept   = in_valid && in_ready;
	assign s2_done  = s2_valid_q && out_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_pc_q <= 32'd0;
			initial_sp_q <= 32'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == CFG_SP) begin
				initial_sp_q <= pwdata;
			end else begin
				initial_pc_q <= pwdata;
			end
		end
	end

	mse_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra     (instruction[25:21]),
		.rb     (instruction[20:16]),
		.a      (a),
		.b      (b),
		.we     (s2_done && res_s2.reg_we),
		.widx   (res_s2.reg_idx),
		.wdata  (rf_wdata)
	);

	mse_exec #(
		.DATA_WORDS (DATA_WORDS)
	) u_exec (
		.func        (func_s1),
		.instruction (instr_s1),
		.load_index  (load_index_s1),
		.load_word   (load_word_s1),
		.a           (a),
		.b           (b),
		.pc          (pc_q),
		.stopped     (stopped_q),
		.initial_pc  (initial_pc_q),
		.initial_sp  (initial_sp_q),
		.res         (exe)
	);

	mse_dmem #(
		.DATA_WORDS (DATA_WORDS),
		.AddrW      (AddrW)
	) u_dmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (s1_valid_q && (exe.load || exe.store)),
		.rd_idx   (AddrW'(exe.mem_idx)),
		.rd_data  (dm_rdata),
		.wr_en    (s2_done && (res_s2.store || res_s2.preload)),
		.wr_idx   (AddrW'(res_s2.mem_idx)),
		.wr_data  (res_s2.store ? st_val : res_s2.wdata),
		.clearing (dm_clearing)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1       <= func;
			instr_s1      <= instruction;
			load_index_s1 <= load_index;
			load_word_s1  <= load_word;
		end
		if (s1_valid_q) begin
			res_s2 <= exe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= 32'd0;
			stopped_q   <= 1'b0;
		end else begin
			s1_valid_q  <= accept;
			s2_valid_q  <= s1_valid_q || (s2_valid_q && !out_free);
			out_valid_q <= s2_done || (out_valid_q && !out_ready);
			if (s1_valid_q) begin
				pc_q      <= exe.pc;
				stopped_q <= exe.stopped;
			end
		end
	end

	always_comb begin
		w_sh = dm_rdata << {res_s2.off, 3'b000};
		case (res_s2.op)
			OP_LH:   ld_val = {{16{w_sh[31]}}, w_sh[31:16]};
			OP_LHU:  ld_val = {16'd0, w_sh[31:16]};
			OP_LB:   ld_val = {{24{w_sh[31]}}, w_sh[31:24]};
			OP_LBU:  ld_val = {24'd0, w_sh[31:24]};
			default: ld_val = w_sh;
		endcase
		st_val = dm_rdata;
		case (res_s2.op)
			OP_SW: st_val = res_s2.wdata;
			OP_SH: begin
				if (res_s2.off == 2'd0) begin
					st_val = {res_s2.wdata[15:0], dm_rdata[15:0]};
				end else begin
					st_val = {dm_rdata[31:16], res_s2.wdata[15:0]};
				end
			end
			OP_SB: begin
				case (res_s2.off)
					2'd0:    st_val[31:24] = res_s2.wdata[7:0];
					2'd1:    st_val[23:16] = res_s2.wdata[7:0];
					2'd2:    st_val[15:8]  = res_s2.wdata[7:0];
					default: st_val[7:0]   = res_s2.wdata[7:0];
				endcase
			end
			default: ;
		endcase
		rf_wdata = res_s2.load ? ld_val : res_s2.reg_val;
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			fetch_pc       <= res_s2.pc;
			reg_write      <= res_s2.reg_report;
			reg_index      <= res_s2.reg_report ? res_s2.reg_idx : 5'd0;
			reg_value      <= res_s2.reg_report ? rf_wdata : 32'd0;
			mem_write      <= res_s2.store;
			mem_index      <= res_s2.store ? 8'(res_s2.mem_idx) : 8'd0;
			mem_value      <= res_s2.store ? st_val : 32'd0;
			err_write_zero <= res_s2.e_zero;
			err_overflow   <= res_s2.e_ovf;
			err_address    <= res_s2.e_addr;
			err_misaligned <= res_s2.e_mis;
			halted         <= res_s2.stopped;
		end
	end

	`ASSERT_CLK(a_accept_fills_s1, clk, arst_n, (in_valid && in_ready) |=> s1_valid_q, "accepted transaction did not enter execute stage")
	`ASSERT_NEVER(a_s1_s2_overlap, clk, arst_n, s1_valid_q && s2_valid_q, "execute stage found memory stage occupied")
	`ASSERT_NEVER(a_item_in_clear, clk, arst_n, dm_clearing && (s1_valid_q || s2_valid_q), "transaction in flight during memory clear")

endmodule

`default_nettype wire

// ===== tb/mips_subset_execute_step_test.sv =====
// Self-checking testbench for the MIPS-subset execute step block.
// Drives preload, start, execute and unused func codes; compares every result
// with a behavioral model of the core. Depends on mse_pkg and the block's RTL.
`timescale 1ns / 100ps

module mips_subset_execute_step_test;
	import mse_pkg::*;

	localparam int MEM_WORDS = 256;
	localparam logic [2:0] ADDR_PC = 3'd0;
	localparam logic [2:0] ADDR_SP = 3'd4;

	typedef struct packed {
		logic [31:0] fetch_pc;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [7:0]  mem_index;
		logic [31:0] mem_value;
		logic        err_write_zero;
		logic        err_overflow;
		logic        err_address;
		logic        err_misaligned;
		logic        halted;
	} step_result_t;

	typedef struct {
		logic [1:0]   fn;
		logic [31:0]  ins;
		logic [7:0]   idx;
		logic [31:0]  word;
		bit           typed;
		step_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = FN_PRELOAD;
	logic [31:0] instruction = '0;
	logic [7:0] load_index = '0;
	logic [31:0] load_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] fetch_pc;
	logic reg_write, mem_write;
	logic [4:0] reg_index;
	logic [31:0] reg_value, mem_value;
	logic [7:0] mem_index;
	logic err_write_zero, err_overflow, err_address, err_misaligned, halted;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	mips_subset_execute_step u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .instruction(instruction),
		.load_index(load_index), .load_word(load_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.fetch_pc(fetch_pc), .reg_write(reg_write), .reg_index(reg_index),
		.reg_value(reg_value), .mem_write(mem_write), .mem_index(mem_index),
		.mem_value(mem_value), .err_write_zero(err_write_zero),
		.err_overflow(err_overflow), .err_address(err_address),
		.err_misaligned(err_misaligned), .halted(halted),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model state of the core.
	logic [31:0] gpr [32];
	logic [31:0] dmem [MEM_WORDS];
	logic [31:0] pc_q;
	bit          stop_q;
	logic [31:0] boot_pc, boot_sp;
	step_result_t cur;

	step_result_t pending_results[$];
	int errors = 0;
	int n_sent = 0, n_checked = 0, n_exec = 0, n_halts = 0;
	bit idle_free = 1'b0;

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] add_ovf(logic [31:0] a, logic [31:0] b);
		logic [31:0] s;
		s = a + b;
		if (a[31] == b[31] && s[31] != a[31])
			cur.err_overflow = 1'b1;
		return s;
	endfunction

	function automatic void set_gpr(logic [4:0] i, logic [31:0] v);
		if (i == 5'd0)
			return;
		gpr[i] = v;
		cur.reg_write = 1'b1;
		cur.reg_index = i;
		cur.reg_value = v;
	endfunction

	function automatic bit access_fault(logic [31:0] addr, int unsigned size);
		bit bad;
		longint unsigned a;
		bad = 1'b0;
		a = addr;
		if (a + size > MEM_WORDS * 4) begin
			cur.err_address = 1'b1;
			bad = 1'b1;
		end
		if ((addr & (size - 1)) != 0) begin
			cur.err_misaligned = 1'b1;
			bad = 1'b1;
		end
		return bad;
	endfunction

	// Returns 1 when the instruction stops the core.
	function automatic bit run_rtype(logic [31:0] ins, ref logic [31:0] npc);
		logic [4:0] rd, sh;
		logic [5:0] fn;
		logic [31:0] a, b, r;
		bit skip;
		rd = ins[15:11];
		sh = ins[10:6];
		fn = ins[5:0];
		a = gpr[ins[25:21]];
		b = gpr[ins[20:16]];
		skip = 1'b0;
		r = '0;
		if (ins[10:0] == 11'd0 && ins[20:16] == 5'd0 && rd == 5'd0)
			return 1'b0;
		if (fn != F_JR && rd == 5'd0) begin
			cur.err_write_zero = 1'b1;
			if (fn != F_ADD && fn != F_SUB)
				return 1'b0;
			skip = 1'b1;
		end
		case (fn)
			F_ADD: r = add_ovf(a, b);
			F_ADDU: r = a + b;
			F_SUB: begin
				r = a - b;
				if (a[31] != b[31] && r[31] != a[31])
					cur.err_overflow = 1'b1;
			end
			F_AND: r = a & b;
			F_OR: r = a | b;
			F_XOR: r = a ^ b;
			F_NOR: r = ~(a | b);
			F_NAND: r = ~(a & b);
			F_SLT: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			F_SLL: r = b << sh;
			F_SRL: r = b >> sh;
			F_SRA: r = $unsigned($signed(b) >>> sh);
			F_JR: begin
				npc = a;
				return 1'b0;
			end
			default: return 1'b1;
		endcase
		if (!skip)
			set_gpr(rd, r);
		return 1'b0;
	endfunction

	function automatic bit run_instruction(logic [31:0] ins, ref logic [31:0] npc);
		logic [5:0] op;
		logic [4:0] rt;
		logic [31:0] a, b, imm, uimm, link, addr, w, t;
		int unsigned size, sft;
		bit wr_ok;
		op = ins[31:26];
		rt = ins[20:16];
		a = gpr[ins[25:21]];
		b = gpr[rt];
		imm = sx16(ins[15:0]);
		uimm = {16'd0, ins[15:0]};
		link = pc_q + 32'd4;
		wr_ok = 1'b1;
		if (op >= OP_ADDI && op <= OP_LHU && rt == 5'd0) begin
			cur.err_write_zero = 1'b1;
			wr_ok = 1'b0;
		end
		case (op)
			OP_RTYPE: return run_rtype(ins, npc);
			OP_ADDI: begin
				t = add_ovf(a, imm);
				if (wr_ok) set_gpr(rt, t);
			end
			OP_ADDI_NV: if (wr_ok) set_gpr(rt, a + imm);
			OP_LUI: if (wr_ok) set_gpr(rt, uimm << 16);
			OP_ANDI: if (wr_ok) set_gpr(rt, a & uimm);
			OP_ORI: if (wr_ok) set_gpr(rt, a | uimm);
			OP_NORI: if (wr_ok) set_gpr(rt, ~(a | uimm));
			OP_SLTI: if (wr_ok) set_gpr(rt, ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0);
			OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU: begin
				addr = add_ovf(a, imm);
				size = (op == OP_LW) ? 4 : (op == OP_LH || op == OP_LHU) ? 2 : 1;
				if (access_fault(addr, size))
					return 1'b1;
				w = dmem[addr[9:2]] << (8 * addr[1:0]);
				case (op)
					OP_LW: t = w;
					OP_LH: t = sx16(w[31:16]);
					OP_LHU: t = {16'd0, w[31:16]};
					OP_LB: t = {{24{w[31]}}, w[31:24]};
					default: t = {24'd0, w[31:24]};
				endcase
				if (wr_ok) set_gpr(rt, t);
			end
			OP_SW, OP_SH, OP_SB: begin
				addr = add_ovf(a, imm);
				size = (op == OP_SW) ? 4 : (op == OP_SH) ? 2 : 1;
				if (access_fault(addr, size))
					return 1'b1;
				t = dmem[addr[9:2]];
				if (op == OP_SW)
					t = b;
				else if (op == OP_SH)
					t = (addr[1:0] == 2'd0) ? {b[15:0], t[15:0]} : {t[31:16], b[15:0]};
				else begin
					sft = (3 - addr[1:0]) * 8;
					t = (t & ~(32'hff << sft)) | ({24'd0, b[7:0]} << sft);
				end
				dmem[addr[9:2]] = t;
				cur.mem_write = 1'b1;
				cur.mem_index = addr[9:2];
				cur.mem_value = t;
			end
			OP_BEQ, OP_BNE, OP_BGTZ: begin
				t = add_ovf(link, imm << 2);
				if ((op == OP_BEQ && a == b) || (op == OP_BNE && a != b) ||
				    (op == OP_BGTZ && a != 0 && !a[31]))
					npc = t;
			end
			OP_JAL: begin
				set_gpr(REG_RA, link);
				npc = {link[31:28], ins[25:0], 2'b00};
			end
			OP_J: npc = {link[31:28], ins[25:0], 2'b00};
			default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	function automatic step_result_t predict_step(logic [1:0] fn, logic [31:0] ins,
	                                              logic [7:0] idx, logic [31:0] word);
		logic [31:0] npc;
		cur = '0;
		if (fn == FN_PRELOAD) begin
			dmem[idx] = word;
		end else if (fn == FN_START) begin
			pc_q = boot_pc;
			gpr[REG_SP] = boot_sp;
			stop_q = 1'b0;
		end else if (fn == FN_EXEC && !stop_q) begin
			npc = pc_q + 32'd4;
			if (run_instruction(ins, npc))
				stop_q = 1'b1;
			else
				pc_q = npc;
		end
		cur.fetch_pc = pc_q;
		cur.halted = stop_q;
		return cur;
	endfunction

	task automatic apb_write(logic [2:0] a, logic [31:0] d);
		paddr <= a;
		pwdata <= d;
		pwrite <= 1'b1;
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == ADDR_PC)
			boot_pc = d;
		else
			boot_sp = d;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Sends one transaction; a typed expectation overrides the model's one.
	task automatic send_item(logic [1:0] fn, logic [31:0] ins, logic [7:0] idx,
	                         logic [31:0] word, bit typed = 1'b0,
	                         step_result_t res = '0);
		step_result_t p;
		while (!idle_free && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		func <= fn;
		instruction <= ins;
		load_index <= idx;
		load_word <= word;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = predict_step(fn, ins, idx, word);
		if (typed && p != res) begin
			$display("%0t: typed row disagrees with model exp=%h act=%h", $time, res, p);
			errors++;
		end
		pending_results.push_back(typed ? res : p);
		n_sent++;
		if (fn == FN_EXEC) n_exec++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 7);

	always @(posedge clk) begin
		step_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{fetch_pc, reg_write, reg_index, reg_value, mem_write, mem_index,
			        mem_value, err_write_zero, err_overflow, err_address,
			        err_misaligned, halted};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (got.halted) n_halts++;
				if (got != want) begin
					$display("%0t: mismatch exp=%h act=%h", $time, want, got);
					if (got.fetch_pc != want.fetch_pc)
						$display("  fetch_pc exp=%h act=%h", want.fetch_pc, got.fetch_pc);
					if (got.reg_value != want.reg_value)
						$display("  reg_value exp=%h act=%h", want.reg_value, got.reg_value);
					if (got.mem_value != want.mem_value)
						$display("  mem_value exp=%h act=%h", want.mem_value, got.mem_value);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] enc_r(logic [5:0] fn, int rs, int rt, int rd, int sh);
		return {OP_RTYPE, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, int rs, int rt, logic [15:0] imm);
		return {op, 5'(rs), 5'(rt), imm};
	endfunction

	function automatic int pick_reg();
		return ($urandom_range(9) == 0) ? 0 : $urandom_range(31);
	endfunction

	function automatic logic [31:0] random_instruction();
		logic [5:0] rfn [13] = '{F_SLL, F_SRL, F_SRA, F_JR, F_ADD, F_ADDU, F_SUB,
		                         F_AND, F_OR, F_XOR, F_NOR, F_NAND, F_SLT};
		logic [5:0] alu [7] = '{OP_ADDI, OP_ADDI_NV, OP_SLTI, OP_ANDI, OP_ORI,
		                        OP_NORI, OP_LUI};
		logic [5:0] mops [8] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB,
		                         OP_SH, OP_SW};
		logic [5:0] ctl [5] = '{OP_BEQ, OP_BNE, OP_BGTZ, OP_J, OP_JAL};
		logic [15:0] off;
		int k;
		k = $urandom_range(99);
		if (k < 30)
			return enc_r(rfn[$urandom_range(12)], pick_reg(), pick_reg(), pick_reg(),
			             $urandom_range(31));
		if (k < 55)
			return enc_i(alu[$urandom_range(6)], pick_reg(), pick_reg(), 16'($urandom));
		if (k < 80) begin
			// Base $0 keeps most addresses inside memory and mostly aligned.
			off = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1023));
			if ($urandom_range(3) != 0) off[1:0] = 2'b00;
			return enc_i(mops[$urandom_range(7)], ($urandom_range(3) == 0) ? pick_reg() : 0,
			             pick_reg(), off);
		end
		if (k < 95)
			return {ctl[$urandom_range(4)], 26'($urandom)};
		return $urandom;
	endfunction

	stim_row_t directed[$];

	task automatic add_row(logic [1:0] fn, logic [31:0] ins, logic [7:0] idx,
	                       logic [31:0] word, bit typed = 1'b0, step_result_t res = '0);
		stim_row_t r;
		r.fn = fn;
		r.ins = ins;
		r.idx = idx;
		r.word = word;
		r.typed = typed;
		r.res = res;
		directed.push_back(r);
	endtask

	initial begin
		step_result_t e;
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
		pc_q = '0;
		stop_q = 1'b0;
		boot_pc = '0;
		boot_sp = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part.
		e = '0;
		e.fetch_pc = 32'd4;
		add_row(FN_EXEC, 32'h0, 8'd0, 32'd0, 1'b1, e);
		add_row(FN_PRELOAD, 32'd0, 8'd255, 32'hffff_ffff, 1'b1, e);
		add_row(FN_PRELOAD, 32'd0, 8'd0, 32'h8000_7f01);
		add_row(2'd3, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1'b1, e);
		add_row(FN_EXEC, enc_i(OP_LUI, 0, 1, 16'h7fff), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_ORI, 1, 1, 16'hffff), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_r(F_ADD, 1, 1, 2, 0), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_r(F_SUB, 0, 1, 0, 0), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_r(F_NAND, 1, 2, 3, 0), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_NORI, 2, 4, 16'h00f0), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_ADDI, 1, 0, 16'h0001), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_r(F_SRA, 0, 2, 5, 31), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_LB, 0, 6, 16'h0000), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_LHU, 0, 7, 16'h0002), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_SB, 0, 1, 16'h03ff), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_SH, 0, 2, 16'h03fe), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_BEQ, 0, 0, 16'h7fff), 8'd0, 32'd0);
		add_row(FN_EXEC, {OP_JAL, 26'h3ff_ffff}, 8'd0, 32'd0);
		add_row(FN_EXEC, enc_r(F_JR, 31, 0, 0, 0), 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_LW, 0, 8, 16'h0002), 8'd0, 32'd0);
		add_row(FN_START, 32'd0, 8'd0, 32'd0);
		add_row(FN_EXEC, enc_i(OP_SW, 0, 8, 16'h8000), 8'd0, 32'd0);
		add_row(FN_START, 32'd0, 8'd0, 32'd0);
		add_row(FN_EXEC, {6'h3f, 26'h0}, 8'd0, 32'd0);
		add_row(FN_EXEC, enc_r(F_ADDU, 1, 1, 9, 0), 8'd0, 32'd0);
		foreach (directed[i])
			send_item(directed[i].fn, directed[i].ins, directed[i].idx, directed[i].word,
			          directed[i].typed, directed[i].res);
		wait_drained();

		// Random part in phases with different start registers.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin apb_write(ADDR_PC, 32'hffff_fff0); apb_write(ADDR_SP, 32'hffff_ffff); end
				1: begin apb_write(ADDR_PC, 32'h7fff_fffc); apb_write(ADDR_SP, 32'h7fff_ffff); end
				2: begin apb_write(ADDR_PC, 32'h0); apb_write(ADDR_SP, 32'h0); end
				default: begin apb_write(ADDR_PC, $urandom); apb_write(ADDR_SP, $urandom); end
			endcase
			idle_free = (ph == 3);
			send_item(FN_START, $urandom, 8'($urandom), $urandom);
			for (int n = 0; n < 310; n++) begin
				case ($urandom_range(19))
					0: send_item(FN_PRELOAD, $urandom, 8'($urandom), $urandom);
					1: send_item(FN_START, $urandom, 8'($urandom), $urandom);
					2: send_item(2'd3, $urandom, 8'($urandom), $urandom);
					default: send_item(FN_EXEC, random_instruction(), 8'($urandom), $urandom);
				endcase
				if (stop_q && $urandom_range(3) == 0)
					send_item(FN_START, $urandom, 8'($urandom), $urandom);
			end
			idle_free = 1'b0;
			wait_drained();
		end

		wait_drained();
		$display("Checked %0d of %0d transactions, %0d executes, %0d halted results.",
		         n_checked, n_sent, n_exec, n_halts);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
